### rtl/dgie_pkg.sv
// Shared types and constants of the depth-gated illuminant estimator.
package dgie_pkg;

  // Command codes of an input beat.
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Register indexes on the configuration port (byte address is four times the index).
  localparam logic [2:0] REG_ROWS  = 3'd0;
  localparam logic [2:0] REG_COLS  = 3'd1;
  localparam logic [2:0] REG_BLEND = 3'd2;
  localparam logic [2:0] REG_GAIN  = 3'd3;
  localparam logic [2:0] REG_TOL   = 3'd4;
  localparam logic [2:0] REG_ITERS = 3'd5;

  localparam int REG_ADDR_W  = 5;
  localparam int DATA_W      = 32;
  localparam int DIM_W       = 9;
  localparam int WORD_W      = 16;
  localparam int OUT_W       = 20;
  localparam int BLEND_SHIFT = 16;
  localparam int GAIN_SHIFT  = 12;

  // Configuration register contents as seen by the datapath.
  typedef struct packed {
    logic [DIM_W-1:0]  rows;
    logic [DIM_W-1:0]  cols;
    logic [WORD_W-1:0] weight;
    logic [WORD_W-1:0] gain;
    logic [WORD_W-1:0] tol;
    logic [WORD_W-1:0] iters;
  } cfg_t;

endpackage

### rtl/dgie_in_if.sv
// Input channel: command beats with pixel payload.
interface dgie_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] pixel_index;
  logic [15:0] direct_sample;
  logic [15:0] depth_sample;

  modport source (output valid, opcode, pixel_index, direct_sample, depth_sample,
                  input ready);
  modport sink (input valid, opcode, pixel_index, direct_sample, depth_sample,
                output ready);
endinterface

### rtl/dgie_out_if.sv
// Output channel: result beats.
interface dgie_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] illuminant_value;
  logic        run_done;
  logic        index_error;

  modport source (output valid, illuminant_value, run_done, index_error, input ready);
  modport sink (input valid, illuminant_value, run_done, index_error, output ready);
endinterface

### rtl/dgie_ram.sv
// Generic single-port synchronous RAM with registered read data.
module dgie_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle; a read returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

### rtl/dgie_regs.sv
// Configuration register bank behind the APB-style port.
module dgie_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dgie_pkg::REG_ADDR_W-1:0]   paddr,
  input  logic [dgie_pkg::DATA_W-1:0]       pwdata,
  output logic [dgie_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  output dgie_pkg::cfg_t                    cfg_o
);
  import dgie_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] reg_sel;

  assign reg_sel = paddr[4:2];
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // Register writes in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows   <= 9'd256;
      cfg_q.cols   <= 9'd256;
      cfg_q.weight <= 16'd655;
      cfg_q.gain   <= 16'd8192;
      cfg_q.tol    <= 16'd8;
      cfg_q.iters  <= 16'd100;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_ROWS:  cfg_q.rows   <= pwdata[DIM_W-1:0];
        REG_COLS:  cfg_q.cols   <= pwdata[DIM_W-1:0];
        REG_BLEND: cfg_q.weight <= pwdata[WORD_W-1:0];
        REG_GAIN:  cfg_q.gain   <= pwdata[WORD_W-1:0];
        REG_TOL:   cfg_q.tol    <= pwdata[WORD_W-1:0];
        REG_ITERS: cfg_q.iters  <= pwdata[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (reg_sel)
      REG_ROWS:  prdata = DATA_W'(cfg_q.rows);
      REG_COLS:  prdata = DATA_W'(cfg_q.cols);
      REG_BLEND: prdata = DATA_W'(cfg_q.weight);
      REG_GAIN:  prdata = DATA_W'(cfg_q.gain);
      REG_TOL:   prdata = DATA_W'(cfg_q.tol);
      REG_ITERS: prdata = DATA_W'(cfg_q.iters);
      default:   prdata = '0;
    endcase
  end
endmodule

### rtl/dgie_blend.sv
// Four-stage pipeline: neighbor average, then blend with the direct sample.
module dgie_blend #(
  parameter int SW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [SW+1:0] sum_i,
  input  logic [2:0]    cnt_i,
  input  logic [SW-1:0] own_i,
  input  logic [SW-1:0] sample_i,
  input  logic [15:0]   weight_i,
  output logic          valid_o,
  output logic [SW-1:0] level_o
);
  import dgie_pkg::*;

  // Division by three as a multiply by a rounded-up reciprocal; exact for sums below 2**K.
  localparam int K = (SW % 2 == 0) ? SW + 3 : SW + 2;
  localparam logic [K-1:0] RECIP3 = K'(((64'd1 << K) + 64'd1) / 64'd3);

  logic [3:0]        vld_q;
  logic [SW+K+1:0]   prod3_q;
  logic [SW+1:0]     sum_q;
  logic [2:0]        cnt_q;
  logic [SW-1:0]     own_q;
  logic [SW-1:0]     samp1_q;
  logic [SW-1:0]     samp2_q;
  logic [SW-1:0]     avg_q;
  logic [SW-1:0]     avg_d;
  logic [SW+15:0]    pa_q;
  logic [SW+16:0]    pb_q;
  logic [16:0]       keep;
  logic [SW+17:0]    total;
  logic [SW+1:0]     half;
  logic [SW+1:0]     quarter;

  assign keep    = 17'h10000 - {1'b0, weight_i};
  assign half    = sum_q >> 1;
  assign quarter = sum_q >> 2;
  assign total   = (SW+18)'(pa_q) + (SW+18)'(pb_q);

  // Average picked by the number of qualifying neighbors.
  always_comb begin
    unique case (cnt_q)
      3'd1:    avg_d = sum_q[SW-1:0];
      3'd2:    avg_d = half[SW-1:0];
      3'd3:    avg_d = prod3_q[K +: SW];
      3'd4:    avg_d = quarter[SW-1:0];
      default: avg_d = own_q;
    endcase
  end

  // Valid shift line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  // Payload stages.
  always_ff @(posedge clk_i) begin
    prod3_q <= (SW+K+2)'(sum_i) * (SW+K+2)'(RECIP3);
    sum_q   <= sum_i;
    cnt_q   <= cnt_i;
    own_q   <= own_i;
    samp1_q <= sample_i;
    avg_q   <= avg_d;
    samp2_q <= samp1_q;
    pa_q    <= (SW+16)'(samp2_q) * (SW+16)'(weight_i);
    pb_q    <= (SW+17)'(avg_q) * (SW+17)'(keep);
    level_o <= total[BLEND_SHIFT +: SW];
  end

  assign valid_o = vld_q[3];
endmodule

### rtl/depth_gated_illuminant_estimator.sv
// Top level of the depth-gated illuminant estimator.
// Loads take one beat per cycle while no pending result holds the output register back;
// a read returns its result through the read-back state. A run first clears level map A
// with one write a cycle over all MAX_ROWS*MAX_COLS entries (the same clearing pass
// follows reset, and no beat is taken until it ends), then, for each pixel and pass,
// fetches the pixel and its four neighbors on one shared address in the fetch steps and
// waits for the blend pipeline. Results wait in an output register.
module depth_gated_illuminant_estimator #(
  parameter int MAX_ROWS    = 256,
  parameter int MAX_COLS    = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  dgie_in_if.sink                         in_if,
  dgie_out_if.source                      out_if,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dgie_pkg::REG_ADDR_W-1:0] paddr,
  input  logic [dgie_pkg::DATA_W-1:0]     pwdata,
  output logic [dgie_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);
  import dgie_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = SAMPLE_BITS;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_FETCH = 5'b01000,
    S_BLEND = 5'b10000
  } state_e;

  cfg_t              cfg;
  state_e            state_q;
  logic [2:0]        step_q;
  logic [DIM_W-1:0]  r_q;
  logic [DIM_W-1:0]  c_q;
  logic [AW-1:0]     i_q;
  logic [15:0]       pass_q;
  logic              sel_q;
  logic [AW-1:0]     clr_q;
  logic              run_pend_q;
  logic [15:0]       depth_c_q;
  logic [SW-1:0]     own_q;
  logic [SW-1:0]     samp_q;
  logic [SW+1:0]     sum_q;
  logic [2:0]        cnt_q;
  logic              out_valid_q;
  logic [OUT_W-1:0]  out_value_q;
  logic              out_done_q;
  logic              out_err_q;

  logic [DIM_W-1:0]  rows_eff;
  logic [DIM_W-1:0]  cols_eff;
  logic [2*DIM_W-1:0] limit;
  logic              idx_bad;
  logic              in_fire;
  logic [AW-1:0]     in_addr;
  logic [AW-1:0]     cols_a;
  logic [AW-1:0]     fetch_addr;
  logic [AW-1:0]     lvl_addr;
  logic [AW-1:0]     px_addr;
  logic              a_we;
  logic              b_we;
  logic [SW-1:0]     lvl_wdata;
  logic [SW-1:0]     a_rd;
  logic [SW-1:0]     b_rd;
  logic [SW-1:0]     src_rd;
  logic [SW-1:0]     samp_rd;
  logic [15:0]       depth_rd;
  logic              px_we;
  logic [3:0]        nb_ok;
  logic [1:0]        nb_sel;
  logic [15:0]       diff;
  logic              near;
  logic              blend_start;
  logic              blend_valid;
  logic [SW-1:0]     blend_level;
  logic [SW+31:0]    gain_prod;
  logic              last_col;
  logic              last_row;

  dgie_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Effective geometry: zero counts as one, large values saturate.
  always_comb begin
    if (cfg.rows == '0) begin
      rows_eff = DIM_W'(1);
    end else if (int'(cfg.rows) > MAX_ROWS) begin
      rows_eff = DIM_W'(MAX_ROWS);
    end else begin
      rows_eff = cfg.rows;
    end
    if (cfg.cols == '0) begin
      cols_eff = DIM_W'(1);
    end else if (int'(cfg.cols) > MAX_COLS) begin
      cols_eff = DIM_W'(MAX_COLS);
    end else begin
      cols_eff = cfg.cols;
    end
  end

  assign limit   = (2*DIM_W)'(rows_eff) * (2*DIM_W)'(cols_eff);
  assign idx_bad = (2*DIM_W)'(in_if.pixel_index) >= limit;
  assign in_addr = AW'(in_if.pixel_index);
  assign cols_a  = AW'(cols_eff);

  assign in_if.ready = (state_q == S_IDLE) && (!out_valid_q || out_if.ready);
  assign in_fire     = in_if.valid && in_if.ready;

  // Address of the pixel or neighbor fetched at each step.
  always_comb begin
    unique case (step_q)
      3'd1:    fetch_addr = i_q - cols_a;
      3'd2:    fetch_addr = i_q + cols_a;
      3'd3:    fetch_addr = i_q - AW'(1);
      3'd4:    fetch_addr = i_q + AW'(1);
      default: fetch_addr = i_q;
    endcase
  end

  // Memory port steering; the two level maps share one address.
  always_comb begin
    unique case (state_q)
      S_CLEAR: lvl_addr = clr_q;
      S_FETCH: lvl_addr = fetch_addr;
      S_BLEND: lvl_addr = i_q;
      default: lvl_addr = in_addr;
    endcase
  end

  assign px_addr   = (state_q == S_FETCH) ? fetch_addr : in_addr;
  assign px_we     = in_fire && (in_if.opcode == OP_LOAD) && !idx_bad;
  assign a_we      = (state_q == S_CLEAR) || (blend_valid && sel_q);
  assign b_we      = blend_valid && !sel_q;
  assign lvl_wdata = (state_q == S_CLEAR) ? '0 : blend_level;
  assign src_rd    = sel_q ? b_rd : a_rd;

  dgie_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_sample_ram (
    .clk_i (clk_i), .we_i (px_we), .addr_i (px_addr),
    .wdata_i (SW'(in_if.direct_sample)), .rdata_o (samp_rd)
  );

  dgie_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_depth_ram (
    .clk_i (clk_i), .we_i (px_we), .addr_i (px_addr),
    .wdata_i (in_if.depth_sample), .rdata_o (depth_rd)
  );

  dgie_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_level_a_ram (
    .clk_i (clk_i), .we_i (a_we), .addr_i (lvl_addr),
    .wdata_i (lvl_wdata), .rdata_o (a_rd)
  );

  dgie_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_level_b_ram (
    .clk_i (clk_i), .we_i (b_we), .addr_i (lvl_addr),
    .wdata_i (lvl_wdata), .rdata_o (b_rd)
  );

  // Neighbor qualification: inside the image and close enough in depth.
  assign nb_ok  = {(c_q + DIM_W'(1)) < cols_eff, c_q != '0,
                   (r_q + DIM_W'(1)) < rows_eff, r_q != '0};
  assign nb_sel = 2'(step_q - 3'd2);
  assign diff   = (depth_rd > depth_c_q) ? depth_rd - depth_c_q : depth_c_q - depth_rd;
  assign near   = diff < cfg.tol;

  assign blend_start = (state_q == S_FETCH) && (step_q == 3'd6);
  assign last_col    = (c_q + DIM_W'(1)) == cols_eff;
  assign last_row    = (r_q + DIM_W'(1)) == rows_eff;

  dgie_blend #(.SW(SW)) u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (blend_start),
    .sum_i    (sum_q),
    .cnt_i    (cnt_q),
    .own_i    (own_q),
    .sample_i (samp_q),
    .weight_i (cfg.weight),
    .valid_o  (blend_valid),
    .level_o  (blend_level)
  );

  // Output gain applied to the level read back.
  assign gain_prod = (SW+32)'(sel_q ? b_rd : a_rd) * (SW+32)'(cfg.gain);

  // Sequencer: clearing pass, command handling and the per-pixel run loop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      step_q      <= '0;
      r_q         <= '0;
      c_q         <= '0;
      i_q         <= '0;
      pass_q      <= '0;
      sel_q       <= 1'b0;
      clr_q       <= '0;
      run_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          if (clr_q == AW'(DEPTH - 1)) begin
            clr_q  <= '0;
            sel_q  <= 1'b0;
            pass_q <= '0;
            r_q    <= '0;
            c_q    <= '0;
            i_q    <= '0;
            step_q <= '0;
            if (run_pend_q) begin
              run_pend_q <= 1'b0;
              if (cfg.iters == '0) begin
                out_valid_q <= 1'b1;
                out_value_q <= '0;
                out_done_q  <= 1'b1;
                out_err_q   <= 1'b0;
                state_q     <= S_IDLE;
              end else begin
                state_q <= S_FETCH;
              end
            end else begin
              state_q <= S_IDLE;
            end
          end else begin
            clr_q <= clr_q + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            case (in_if.opcode)
              OP_LOAD: begin
                if (idx_bad) begin
                  out_valid_q <= 1'b1;
                  out_value_q <= '0;
                  out_done_q  <= 1'b0;
                  out_err_q   <= 1'b1;
                end
              end
              OP_RUN: begin
                run_pend_q <= 1'b1;
                state_q    <= S_CLEAR;
              end
              OP_READ: begin
                if (idx_bad) begin
                  out_valid_q <= 1'b1;
                  out_value_q <= '0;
                  out_done_q  <= 1'b0;
                  out_err_q   <= 1'b1;
                end else begin
                  state_q <= S_READ;
                end
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          out_valid_q <= 1'b1;
          out_value_q <= gain_prod[GAIN_SHIFT +: OUT_W];
          out_done_q  <= 1'b0;
          out_err_q   <= 1'b0;
          state_q     <= S_IDLE;
        end
        S_FETCH: begin
          if (step_q == 3'd0) begin
            sum_q <= '0;
            cnt_q <= '0;
          end else if (step_q == 3'd1) begin
            depth_c_q <= depth_rd;
            own_q     <= src_rd;
            samp_q    <= samp_rd;
          end else if (step_q != 3'd6) begin
            if (nb_ok[nb_sel] && near) begin
              sum_q <= sum_q + (SW+2)'(src_rd);
              cnt_q <= cnt_q + 3'd1;
            end
          end
          if (step_q == 3'd6) begin
            step_q  <= '0;
            state_q <= S_BLEND;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        S_BLEND: begin
          if (blend_valid) begin
            i_q     <= i_q + AW'(1);
            state_q <= S_FETCH;
            if (last_col) begin
              c_q <= '0;
              if (last_row) begin
                r_q    <= '0;
                i_q    <= '0;
                pass_q <= pass_q + 16'd1;
                sel_q  <= ~sel_q;
                if ((pass_q + 16'd1) == cfg.iters) begin
                  out_valid_q <= 1'b1;
                  out_value_q <= '0;
                  out_done_q  <= 1'b1;
                  out_err_q   <= 1'b0;
                  state_q     <= S_IDLE;
                end
              end else begin
                r_q <= r_q + DIM_W'(1);
              end
            end else begin
              c_q <= c_q + DIM_W'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid            = out_valid_q;
  assign out_if.illuminant_value = out_value_q;
  assign out_if.run_done         = out_done_q;
  assign out_if.index_error      = out_err_q;

`ifndef SYNTHESIS
  // Only one level map is written in any cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(a_we && b_we))
    else $error("both level maps written in one cycle");

  // Blend results arrive only while the sequencer waits for them.
  assert property (@(posedge clk_i) disable iff (!rst_ni) blend_valid |-> state_q == S_BLEND)
    else $error("blend result outside of the blend wait");

  // An in-range read goes to the read-back state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_if.opcode == OP_READ && !idx_bad) |=> state_q == S_READ)
    else $error("in-range read not followed by read-back");

  // The output register is free when read data lands.
  assert property (@(posedge clk_i) disable iff (!rst_ni) state_q == S_READ |-> !out_valid_q)
    else $error("read-back would overwrite a pending result");
`endif
endmodule
